>>> hw/rtl/ptw_pkg.sv
package ptw_pkg;

   localparam int STORE_WORDS = 4096;
   localparam int STORE_AW    = $clog2(STORE_WORDS);

   localparam int WORD_W  = 64;
   localparam int PA_W    = 52;
   localparam int VA_W    = 48;
   localparam int WADDR_W = 12;
   localparam int IDX_W   = 9;
   localparam int FRAME_W = PA_W - 12;
   localparam int TIDX_W  = FRAME_W + IDX_W;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_SIZE    = 7;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_XLATE = 1'b1;

   localparam logic [1:0] PS_4K = 2'd0;
   localparam logic [1:0] PS_2M = 2'd1;
   localparam logic [1:0] PS_1G = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      LVL_PT   = 2'd0,
      LVL_PD   = 2'd1,
      LVL_PDPT = 2'd2,
      LVL_ROOT = 2'd3
   } level_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [WORD_W-1:0]   wdata;
   } mem_req_type;

   function automatic logic [IDX_W-1:0] va_slice(input logic [VA_W-1:0] va,
                                                 input level_type lvl);
      case (lvl)
         LVL_ROOT: va_slice = va[47:39];
         LVL_PDPT: va_slice = va[38:30];
         LVL_PD:   va_slice = va[29:21];
         LVL_PT:   va_slice = va[20:12];
         default:  va_slice = va[20:12];
      endcase
   endfunction

endpackage

>>> hw/rtl/ptw_ram.sv
module ptw_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ptw_ctrl.sv
module ptw_ctrl
   import ptw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [PA_W-1:0]    root_addr,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [WADDR_W-1:0] req_word_addr,
   input  logic [WORD_W-1:0]  req_word_data,
   input  logic [VA_W-1:0]    req_virt_addr,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PA_W-1:0]    rsp_phys_addr,
   output logic               rsp_present,
   output logic [1:0]         rsp_page_size,
   output mem_req_type        mem_req,
   input  logic [WORD_W-1:0]  mem_rd_data
);

   state_type           state_ff, state_in;
   level_type           lvl_ff, lvl_in, lvl_dn;
   logic [STORE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic                oor_ff, oor_in;
   logic [PA_W-1:0]     res_pa_ff, res_pa_in;
   logic                res_pres_ff, res_pres_in;
   logic [1:0]          res_ps_ff, res_ps_in;
   logic                out_valid_ff, out_valid_in;
   logic [PA_W-1:0]     out_pa_ff;
   logic                out_pres_ff;
   logic [1:0]          out_ps_ff;

   logic                accept;
   logic                out_load;
   logic                clr_last;
   logic [WORD_W-1:0]   entry;
   logic                stop;
   logic [PA_W-1:0]     walk_pa;
   logic                walk_pres;
   logic [1:0]          walk_ps;
   logic [TIDX_W-1:0]   tidx;
   logic [TIDX_W-1:0]   wr_idx;
   logic                wr_ok;

   assign accept   = req_valid && !req_stall;
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || !rsp_stall);
   assign clr_last = clr_cnt_ff == STORE_AW'(STORE_WORDS - 1);
   assign lvl_dn   = level_type'(2'(lvl_ff) - 2'd1);
   assign wr_idx   = TIDX_W'(req_word_addr);
   assign wr_ok    = wr_idx < TIDX_W'(STORE_WORDS);

   // entry decode for the word returned by the previous read
   always_comb begin
      entry     = oor_ff ? '0 : mem_rd_data;
      stop      = 1'b1;
      walk_pa   = '0;
      walk_pres = 1'b0;
      walk_ps   = PS_4K;
      if (!entry[BIT_PRESENT]) begin
         stop = 1'b1;
      end else if (lvl_ff == LVL_PDPT && entry[BIT_SIZE]) begin
         walk_pa   = {entry[51:30], va_ff[29:0]};
         walk_pres = 1'b1;
         walk_ps   = PS_1G;
      end else if (lvl_ff == LVL_PD && entry[BIT_SIZE]) begin
         walk_pa   = {entry[51:21], va_ff[20:0]};
         walk_pres = 1'b1;
         walk_ps   = PS_2M;
      end else if (lvl_ff == LVL_PT) begin
         walk_pa   = {entry[51:12], va_ff[11:0]};
         walk_pres = 1'b1;
         walk_ps   = PS_4K;
      end else begin
         stop = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = (req_action == ACT_XLATE) ? ST_ISSUE : ST_DONE;
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stop) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_stall     = state_ff != ST_IDLE;
      mem_req.we    = 1'b0;
      mem_req.addr  = '0;
      mem_req.wdata = '0;
      tidx          = '0;
      clr_cnt_in    = clr_cnt_ff;
      lvl_in        = lvl_ff;
      va_in         = va_ff;
      res_pa_in     = res_pa_ff;
      res_pres_in   = res_pres_ff;
      res_ps_in     = res_ps_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_cnt_ff;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               va_in       = req_virt_addr;
               res_pa_in   = '0;
               res_pres_in = 1'b0;
               res_ps_in   = PS_4K;
               if (req_action == ACT_WRITE && wr_ok) begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = wr_idx[STORE_AW-1:0];
                  mem_req.wdata = req_word_data;
               end
            end
         end
         ST_ISSUE: begin
            tidx         = {root_addr[51:12], va_slice(va_ff, LVL_ROOT)};
            mem_req.addr = tidx[STORE_AW-1:0];
            lvl_in       = LVL_ROOT;
         end
         ST_WAIT: begin
            if (stop) begin
               res_pa_in   = walk_pa;
               res_pres_in = walk_pres;
               res_ps_in   = walk_ps;
            end else begin
               tidx         = {entry[51:12], va_slice(va_ff, lvl_dn)};
               mem_req.addr = tidx[STORE_AW-1:0];
               lvl_in       = lvl_dn;
            end
         end
         default: begin
         end
      endcase
      oor_in       = !(tidx < TIDX_W'(STORE_WORDS));
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         lvl_ff       <= LVL_ROOT;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
         lvl_ff       <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      oor_ff      <= oor_in;
      res_pa_ff   <= res_pa_in;
      res_pres_ff <= res_pres_in;
      res_ps_ff   <= res_ps_in;
      if (out_load) begin
         out_pa_ff   <= res_pa_ff;
         out_pres_ff <= res_pres_ff;
         out_ps_ff   <= res_ps_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_phys_addr = out_pa_ff;
   assign rsp_present   = out_pres_ff;
   assign rsp_page_size = out_ps_ff;

   a_we_only_clear_or_idle: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("store written during a walk");

   a_pt_level_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && lvl_ff == LVL_PT) |=> state_ff == ST_DONE)
      else $error("walk continued past the last level");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_present) |-> (rsp_phys_addr == '0 && rsp_page_size == PS_4K))
      else $error("non-present result carries address or size");

   a_size_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_page_size == PS_4K || rsp_page_size == PS_2M
                     || rsp_page_size == PS_1G))
      else $error("illegal page size code");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(state_ff) == ST_DONE)
      else $error("result beat appeared without a finished item");

endmodule

>>> hw/rtl/four_level_page_table_walker_top.sv
// Four-level page-table walker. After reset the table store (4096 words) is
// swept to zero, one word per cycle, and req_stall stays high for the sweep.
// Items are taken one at a time. A write beat goes from idle straight to the
// done state. A translate beat reads k table levels, k from 1 to 4; each
// level is one dependent read of the single-port table store, and a full 4 KiB
// walk reads all four levels. The next request is taken while a finished
// response still waits in the output register. csr writes set the root
// table address and are to be made only while the block is idle.
module four_level_page_table_walker_top
   import ptw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [WADDR_W-1:0] req_word_addr,
   input  logic [WORD_W-1:0]  req_word_data,
   input  logic [VA_W-1:0]    req_virt_addr,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PA_W-1:0]    rsp_phys_addr,
   output logic               rsp_present,
   output logic [1:0]         rsp_page_size,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [PA_W-1:0]    csr_root_table_addr
);

   logic [PA_W-1:0]   root_ff, root_in;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rd_data;

   assign csr_ready = 1'b1;
   assign root_in   = (csr_valid && csr_ready) ? csr_root_table_addr : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   ptw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .root_addr     (root_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_word_addr (req_word_addr),
      .req_word_data (req_word_data),
      .req_virt_addr (req_virt_addr),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_phys_addr (rsp_phys_addr),
      .rsp_present   (rsp_present),
      .rsp_page_size (rsp_page_size),
      .mem_req       (mem_req),
      .mem_rd_data   (mem_rd_data)
   );

   ptw_ram #(
      .DEPTH (STORE_WORDS),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .we      (mem_req.we),
      .addr    (mem_req.addr),
      .wdata   (mem_req.wdata),
      .rd_data (mem_rd_data)
   );

endmodule

>>> sim/tb_top.sv
module tb_top;
   import ptw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [PA_W-1:0] pa;
      logic            present;
      logic [1:0]      size;
   } walk_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = ACT_WRITE;
   logic [WADDR_W-1:0] req_word_addr = '0;
   logic [WORD_W-1:0]  req_word_data = '0;
   logic [VA_W-1:0]    req_virt_addr = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PA_W-1:0]    rsp_phys_addr;
   logic               rsp_present;
   logic [1:0]         rsp_page_size;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [PA_W-1:0]    csr_root_table_addr = '0;

   logic [WORD_W-1:0] store_model [STORE_WORDS] = '{default: '0};
   logic [PA_W-1:0]   root_model = '0;
   walk_result_type   expected_walks [$];
   walk_result_type   oldest_walk;
   int                mismatches = 0;
   int                beats_sent = 0;
   int                idle_cycles = 0;
   bit                pace_gaps = 1'b1;
   int                burst_left = 0;
   int                stall_mode = 0;
   int                stall_left = 0;
   int unsigned       cyc = 0;

   four_level_page_table_walker_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_word_addr       (req_word_addr),
      .req_word_data       (req_word_data),
      .req_virt_addr       (req_virt_addr),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phys_addr       (rsp_phys_addr),
      .rsp_present         (rsp_present),
      .rsp_page_size       (rsp_page_size),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_root_table_addr (csr_root_table_addr)
   );

   initial forever #1 clock = ~clock;

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // entries of tables past the end of the store read as zero
   function automatic logic [WORD_W-1:0] table_word(input logic [PA_W-1:0] base,
                                                    input logic [IDX_W-1:0] idx);
      logic [63:0] w;
      w = ({12'd0, base[51:12], 12'd0} >> 3) + idx;
      if (w >= STORE_WORDS) return '0;
      return store_model[w[11:0]];
   endfunction

   function automatic walk_result_type predict_walk(input logic [VA_W-1:0] va);
      logic [WORD_W-1:0] e;
      walk_result_type   r;
      r = '0;
      e = table_word(root_model, va[47:39]);
      if (!e[BIT_PRESENT]) return r;
      e = table_word(e[51:0], va[38:30]);
      if (!e[BIT_PRESENT]) return r;
      if (e[BIT_SIZE]) begin
         r.pa = {e[51:30], va[29:0]};
         r.present = 1'b1;
         r.size = PS_1G;
         return r;
      end
      e = table_word(e[51:0], va[29:21]);
      if (!e[BIT_PRESENT]) return r;
      if (e[BIT_SIZE]) begin
         r.pa = {e[51:21], va[20:0]};
         r.present = 1'b1;
         r.size = PS_2M;
         return r;
      end
      e = table_word(e[51:0], va[20:12]);
      if (!e[BIT_PRESENT]) return r;
      r.pa = {e[51:12], va[11:0]};
      r.present = 1'b1;
      r.size = PS_4K;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] pte(input logic [FRAME_W-1:0] frame,
                                             input logic present, input logic size);
      logic [WORD_W-1:0] j;
      j = rand_word();
      return {j[63:52], frame, j[11:8], size, j[6:1], present};
   endfunction

   // mostly one of the eight in-store tables, sometimes a wild frame
   function automatic logic [FRAME_W-1:0] ptr_frame(input logic [2:0] slot);
      logic [WORD_W-1:0] r;
      r = rand_word();
      return ($urandom_range(0, 9) == 0) ? r[FRAME_W-1:0] : {37'd0, slot};
   endfunction

   function automatic logic lvl_present();
      return $urandom_range(0, 9) != 0;
   endfunction

   task automatic send_beat(input logic act, input logic [WADDR_W-1:0] wa,
                            input logic [WORD_W-1:0] wd, input logic [VA_W-1:0] va);
      walk_result_type res;
      int              gap;
      req_valid     <= 1'b1;
      req_action    <= act;
      req_word_addr <= wa;
      req_word_data <= wd;
      req_virt_addr <= va;
      do @(posedge clock); while (req_stall !== 1'b0);
      res = '0;
      if (act == ACT_WRITE) begin
         if (wa < STORE_WORDS) store_model[wa] = wd;
      end else begin
         res = predict_walk(va);
      end
      expected_walks.push_back(res);
      beats_sent++;
      if (pace_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic write_word(input logic [WADDR_W-1:0] wa, input logic [WORD_W-1:0] wd);
      logic [WORD_W-1:0] r;
      r = rand_word();
      send_beat(ACT_WRITE, wa, wd, r[VA_W-1:0]);
   endtask

   task automatic translate(input logic [VA_W-1:0] va);
      logic [WORD_W-1:0] r;
      r = rand_word();
      send_beat(ACT_XLATE, r[WADDR_W-1:0], rand_word(), va);
   endtask

   task automatic drain_walks;
      req_valid <= 1'b0;
      while (expected_walks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_root(input logic [PA_W-1:0] addr);
      drain_walks();
      csr_root_table_addr <= addr;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      root_model = addr;
   endtask

   task automatic test_cleared_store;
      translate('0);
      translate('1);
      translate(48'h8000_0040_2001);
   endtask

   task automatic test_directed_walks;
      set_root(52'h0_0000_0000_1ABC);
      // size bit in a root entry is ignored
      write_word({3'd1, 9'h1FF}, {12'hFFF, 40'd2, 4'hF, 1'b1, 6'h3F, 1'b1});
      write_word({3'd2, 9'h000}, {12'h000, 40'd3, 4'h0, 1'b0, 6'h00, 1'b1});
      write_word({3'd3, 9'h1FF}, {12'hABC, 40'd4, 4'h5, 1'b0, 6'h2A, 1'b1});
      // size bit in a PT entry is ignored
      write_word({3'd4, 9'h000}, {12'hFFF, 40'hFF_FFFF_FFFF, 4'hF, 1'b1, 6'h3F, 1'b1});
      translate({9'h1FF, 9'h000, 9'h1FF, 9'h000, 12'hFFF});
      // present page at physical zero
      write_word({3'd4, 9'h001}, 64'h0000_0000_0000_0001);
      translate({9'h1FF, 9'h000, 9'h1FF, 9'h001, 12'h000});
      write_word({3'd4, 9'h002}, 64'h000F_FFFF_FFFF_FFFE);
      translate({9'h1FF, 9'h000, 9'h1FF, 9'h002, 12'h123});
      write_word({3'd3, 9'h001}, {12'h000, 40'h12_3456_789A, 4'h0, 1'b1, 6'h00, 1'b1});
      translate({9'h1FF, 9'h000, 9'h001, 21'h1F_FFFF});
      write_word({3'd2, 9'h1FF}, {12'h800, 40'hFF_FFFF_FFFF, 4'h0, 1'b1, 6'h00, 1'b1});
      translate({9'h1FF, 9'h1FF, 30'h2AAA_AAAA});
      translate({9'h000, 39'h0});
      translate({9'h1FF, 9'h005, 30'h0});
      translate({9'h1FF, 9'h000, 9'h002, 21'h0});
      // next table just past the end of the store, then far outside
      write_word({3'd2, 9'h003}, {12'h000, 40'd8, 12'h001});
      translate({9'h1FF, 9'h003, 30'h3FFF_FFFF});
      write_word({3'd2, 9'h004}, {12'h000, 40'h80_0000_0000, 12'h001});
      translate({9'h1FF, 9'h004, 30'h0});
      write_word(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      write_word(12'h000, 64'h0);
      translate(48'hFFFF_FFFF_FFFF);
   endtask

   task automatic test_root_extremes;
      set_root(52'hF_FFFF_FFFF_FFFF);
      translate(48'hFFFF_FFFF_FFFF);
      translate('0);
      set_root('0);
      translate('0);
      write_word(12'h000, {12'h000, 40'd2, 12'h001});
      translate({9'h000, 9'h1FF, 30'h1555_5555});
   endtask

   task automatic random_walk_phase(input int quota);
      logic [WORD_W-1:0] r;
      logic [VA_W-1:0]   va;
      logic [2:0]        root_slot, t1, t2, t3;
      logic              big, mid;
      int                stop_at;
      stop_at = beats_sent + quota;
      root_slot = root_model[14:12];
      while (beats_sent < stop_at) begin
         r = rand_word();
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 1)
               write_word(r[WADDR_W-1:0], rand_word());
            else
               translate(r[VA_W-1:0]);
         end else begin
            va = r[VA_W-1:0];
            t1 = 3'($urandom_range(0, 7));
            t2 = 3'($urandom_range(0, 7));
            t3 = 3'($urandom_range(0, 7));
            big = ($urandom_range(0, 4) == 0);
            mid = ($urandom_range(0, 3) == 0);
            write_word({root_slot, va[47:39]},
                       pte(ptr_frame(t1), lvl_present(), $urandom_range(0, 1) == 1));
            write_word({t1, va[38:30]}, pte(ptr_frame(t2), lvl_present(), big));
            if (!big)
               write_word({t2, va[29:21]}, pte(ptr_frame(t3), lvl_present(), mid));
            if (!big && !mid) begin
               r = rand_word();
               write_word({t3, va[20:12]},
                          pte(r[FRAME_W-1:0], lvl_present(), $urandom_range(0, 1) == 1));
            end
            translate(va);
            if ($urandom_range(0, 1) == 1) begin
               r = rand_word();
               translate({va[47:21], r[20:0]});
            end
         end
      end
   endtask

   task automatic test_random_walks;
      logic [WORD_W-1:0] r;
      for (int ph = 0; ph < 4; ph++) begin
         pace_gaps = (ph != 1);
         r = rand_word();
         set_root(ph == 0 ? 52'h0_0000_0000_7FFF : {37'd0, r[14:0]});
         random_walk_phase(155);
      end
      pace_gaps = 1'b1;
   endtask

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cyc[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_walks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: pa=%h present=%b size=%0d",
                        rsp_phys_addr, rsp_present, rsp_page_size);
         end else begin
            oldest_walk = expected_walks.pop_front();
            if (rsp_phys_addr !== oldest_walk.pa || rsp_present !== oldest_walk.present ||
                rsp_page_size !== oldest_walk.size) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"walk mismatch: expected pa=%h present=%b size=%0d, ",
                            "got pa=%h present=%b size=%0d"},
                           oldest_walk.pa, oldest_walk.present, oldest_walk.size,
                           rsp_phys_addr, rsp_present, rsp_page_size);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_cleared_store();
      test_directed_walks();
      test_root_extremes();
      test_random_walks();
      drain_walks();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_walks.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> four_level_page_table_walker_top.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/ptw_ctrl.sv
hw/rtl/four_level_page_table_walker_top.sv
sim/tb_top.sv
